// ===== rtl/kli_pkg.sv =====
// ----------------------------------------------------------------------------
// kli_pkg
// Shared types and constants of the keyframe linear interpolator.
// ----------------------------------------------------------------------------
package kli_pkg;

  localparam int DEF_FRAMES   = 6;
  localparam int DEF_CHANNELS = 9;

  localparam int KEY_W       = 16;   // keyframe value, signed q12.4
  localparam int POS_W       = 32;   // position and increment, signed q16.16
  localparam int FRAC_SHIFT  = 12;   // q12.4 to q16.16
  localparam int OUT_CH      = 9;    // position fields in a result
  localparam int STEP_W      = 10;
  localparam int FRAMES_W    = 3;
  localparam int SEG_OUT_W   = 3;
  localparam int MODE_W      = 2;
  localparam int FIDX_W      = 3;
  localparam int CIDX_W      = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 296;

  // restoring divider: magnitude of a 17 bit difference shifted by FRAC_SHIFT
  localparam int DIV_STEPS   = KEY_W + FRAC_SHIFT;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [STEP_W-1:0]   STEP_COUNT_RST    = 10'd990;
  localparam logic [FRAMES_W-1:0] FRAMES_IN_USE_RST = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 2'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_TOGGLE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD,
    S_LAT,
    S_DIV,
    S_WR,
    S_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic kf_write;
    logic step;
    logic stop_end;
    logic halt;
    logic start;
    logic advance;
    logic rd;
    logic div_start;
    logic div_step;
    logic inc_write;
    logic next_ch;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  playing;
    logic  step_done;
    logic  last_seg;
    logic  ch_last;
    logic  div_last;
    logic  out_busy;
  } status_t;

endpackage

// ===== rtl/kli_ctrl.sv =====
// ----------------------------------------------------------------------------
// kli_ctrl
// Sequencer: decodes each transaction and steps the datapath through the
// per-channel increment computation.
// ----------------------------------------------------------------------------
module kli_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  kli_pkg::status_t status,
  output kli_pkg::cmd_t    cmd
);
  import kli_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        state_nxt = S_OUT;
        case (status.mode)
          MODE_TICK: begin
            if (status.playing && status.step_done && !status.last_seg) state_nxt = S_RD;
          end
          MODE_TOGGLE: begin
            if (!status.playing) state_nxt = S_RD;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_RD:  state_nxt = S_LAT;
      S_LAT: state_nxt = S_DIV;
      S_DIV: begin
        if (status.div_last) state_nxt = S_WR;
      end
      S_WR: begin
        state_nxt = status.ch_last ? S_OUT : S_RD;
      end
      S_OUT: begin
        if (!status.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      S_DECODE: begin
        case (status.mode)
          MODE_LOAD: cmd.kf_write = 1'b1;
          MODE_TICK: begin
            if (status.playing) begin
              if (!status.step_done)    cmd.step     = 1'b1;
              else if (status.last_seg) cmd.stop_end = 1'b1;
              else                      cmd.advance  = 1'b1;
            end
          end
          MODE_TOGGLE: begin
            if (status.playing) cmd.halt  = 1'b1;
            else                cmd.start = 1'b1;
          end
          default: cmd = '0;
        endcase
      end
      S_RD:  cmd.rd        = 1'b1;
      S_LAT: cmd.div_start = 1'b1;
      S_DIV: cmd.div_step  = 1'b1;
      S_WR: begin
        cmd.inc_write = 1'b1;
        cmd.next_ch   = !status.ch_last;
      end
      S_OUT: cmd.out_load = !status.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/kli_datapath.sv =====
// ----------------------------------------------------------------------------
// kli_datapath
// Keyframe memory, positions, increments, play state, shared divider and
// the output register.
// ----------------------------------------------------------------------------
module kli_datapath #(
  parameter int FRAMES   = kli_pkg::DEF_FRAMES,
  parameter int CHANNELS = kli_pkg::DEF_CHANNELS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [kli_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kli_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [kli_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [kli_pkg::MODE_W-1:0]       in_tuser,
  input  kli_pkg::cmd_t                    cmd,
  output kli_pkg::status_t                 status,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [kli_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import kli_pkg::*;

  localparam int DEPTH  = FRAMES * CHANNELS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SEG_W  = $clog2(FRAMES);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // configuration
  logic [STEP_W-1:0]   step_count_r;
  logic [FRAMES_W-1:0] frames_in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r    <= STEP_COUNT_RST;
      frames_in_use_r <= FRAMES_IN_USE_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_STEP_COUNT)    step_count_r    <= cfg_data;
      if (cfg_index == REG_FRAMES_IN_USE) frames_in_use_r <= cfg_data[FRAMES_W-1:0];
    end
  end

  logic [STEP_W-1:0] eff_steps;
  logic [4:0]        eff_frames;

  always_comb begin
    eff_steps = (step_count_r == '0) ? STEP_W'(1) : step_count_r;
    if (frames_in_use_r < 3'd2)                eff_frames = 5'd2;
    else if (32'(frames_in_use_r) > FRAMES)    eff_frames = 5'(FRAMES);
    else                                       eff_frames = 5'(frames_in_use_r);
  end

  // captured transaction
  logic [MODE_W-1:0] mode_r;
  logic [FIDX_W-1:0] frame_r;
  logic [CIDX_W-1:0] chan_in_r;
  logic [KEY_W-1:0]  key_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r    <= in_tuser;
      frame_r   <= in_tdata[FIDX_W-1:0];
      chan_in_r <= in_tdata[FIDX_W +: CIDX_W];
      key_r     <= in_tdata[FIDX_W+CIDX_W +: KEY_W];
    end
  end

  // play state
  logic             playing_r;
  logic [SEG_W-1:0] seg_r;
  logic [STEP_W-1:0] step_cnt_r;
  logic [CH_W-1:0]  ch_r;
  logic             copy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r  <= 1'b0;
      seg_r      <= '0;
      step_cnt_r <= '0;
      ch_r       <= '0;
      copy_r     <= 1'b0;
    end else begin
      if (cmd.step) step_cnt_r <= step_cnt_r + STEP_W'(1);
      if (cmd.stop_end) begin
        playing_r <= 1'b0;
        seg_r     <= '0;
      end
      if (cmd.halt) playing_r <= 1'b0;
      if (cmd.start) begin
        playing_r  <= 1'b1;
        seg_r      <= '0;
        step_cnt_r <= '0;
        ch_r       <= '0;
        copy_r     <= 1'b1;
      end
      if (cmd.advance) begin
        seg_r      <= seg_r + SEG_W'(1);
        step_cnt_r <= '0;
        ch_r       <= '0;
        copy_r     <= 1'b0;
      end
      if (cmd.next_ch) ch_r <= ch_r + CH_W'(1);
    end
  end

  // keyframe memory, entries read as zero until written
  logic [KEY_W-1:0] kf_mem [DEPTH];
  logic [DEPTH-1:0] kf_vld_r;
  logic             wr_ok;
  logic [ADDR_W-1:0] wr_addr, rd_addr_cur, rd_addr_nxt;
  logic [KEY_W-1:0] cur_raw_r, nxt_raw_r;
  logic             cur_vld_r, nxt_vld_r;

  assign wr_ok       = (32'(frame_r) < FRAMES) && (32'(chan_in_r) < CHANNELS);
  assign wr_addr     = ADDR_W'(32'(frame_r) * CHANNELS + 32'(chan_in_r));
  assign rd_addr_cur = ADDR_W'(32'(seg_r) * CHANNELS + 32'(ch_r));
  assign rd_addr_nxt = ADDR_W'((32'(seg_r) + 1) * CHANNELS + 32'(ch_r));

  always_ff @(posedge clk) begin
    if (cmd.kf_write && wr_ok) kf_mem[wr_addr] <= key_r;
    if (cmd.rd) begin
      cur_raw_r <= kf_mem[rd_addr_cur];
      nxt_raw_r <= kf_mem[rd_addr_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kf_vld_r  <= '0;
      cur_vld_r <= 1'b0;
      nxt_vld_r <= 1'b0;
    end else begin
      if (cmd.kf_write && wr_ok) kf_vld_r[wr_addr] <= 1'b1;
      if (cmd.rd) begin
        cur_vld_r <= kf_vld_r[rd_addr_cur];
        nxt_vld_r <= kf_vld_r[rd_addr_nxt];
      end
    end
  end

  logic signed [KEY_W-1:0] cur_key, nxt_key;
  logic signed [KEY_W:0]   diff;
  logic        [KEY_W:0]   diff_mag;

  assign cur_key  = cur_vld_r ? cur_raw_r : '0;
  assign nxt_key  = nxt_vld_r ? nxt_raw_r : '0;
  assign diff     = {nxt_key[KEY_W-1], nxt_key} - {cur_key[KEY_W-1], cur_key};
  assign diff_mag = diff[KEY_W] ? (KEY_W+1)'(-diff) : diff;

  // restoring divider, one quotient bit per cycle
  logic [DIV_STEPS-1:0] dq_r;
  logic [STEP_W-1:0]    rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic                 neg_r;
  logic [STEP_W:0]      trial;
  logic                 fits;

  assign trial = {rem_r, dq_r[DIV_STEPS-1]};
  assign fits  = trial >= {1'b0, eff_steps};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq_r      <= {diff_mag[KEY_W-1:0], FRAC_SHIFT'(0)};
      rem_r     <= '0;
      div_cnt_r <= '0;
      neg_r     <= diff[KEY_W];
    end else if (cmd.div_step) begin
      rem_r     <= fits ? STEP_W'(trial - {1'b0, eff_steps}) : trial[STEP_W-1:0];
      dq_r      <= {dq_r[DIV_STEPS-2:0], fits};
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  logic [POS_W-1:0] quot_ext, inc_val;

  assign quot_ext = POS_W'(dq_r);
  assign inc_val  = neg_r ? -quot_ext : quot_ext;

  // positions and increments
  logic [POS_W-1:0] pos_r [CHANNELS];
  logic [POS_W-1:0] inc_r [CHANNELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        pos_r[c] <= '0;
        inc_r[c] <= '0;
      end
    end else begin
      if (cmd.step) begin
        for (int c = 0; c < CHANNELS; c++) pos_r[c] <= pos_r[c] + inc_r[c];
      end
      if (cmd.div_start && copy_r) begin
        pos_r[ch_r] <= {{(POS_W-KEY_W-FRAC_SHIFT){cur_key[KEY_W-1]}}, cur_key,
                        FRAC_SHIFT'(0)};
      end
      if (cmd.inc_write) inc_r[ch_r] <= inc_val;
    end
  end

  // status
  always_comb begin
    status.mode      = mode_t'(mode_r);
    status.playing   = playing_r;
    status.step_done = step_cnt_r >= eff_steps;
    status.last_seg  = (32'(seg_r) + 2) >= 32'(eff_frames);
    status.ch_last   = 32'(ch_r) == (CHANNELS - 1);
    status.div_last  = 32'(div_cnt_r) == (DIV_STEPS - 1);
    status.out_busy  = out_tvalid && !out_tready;
  end

  // result register
  logic [OUT_TDATA_W-1:0] result;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  for (genvar g = 0; g < OUT_CH; g++) begin : g_pos
    if (g < CHANNELS) begin : g_live
      assign result[g*POS_W +: POS_W] = pos_r[g];
    end else begin : g_absent
      assign result[g*POS_W +: POS_W] = '0;
    end
  end
  assign result[OUT_CH*POS_W]                    = playing_r;
  assign result[OUT_CH*POS_W+1 +: SEG_OUT_W]     = SEG_OUT_W'(seg_r);
  assign result[OUT_TDATA_W-1:OUT_CH*POS_W+1+SEG_OUT_W] = '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data_r <= result;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/keyframe_linear_interpolator.sv =====
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator
// Nine-channel keyframe animator with linear interpolation between frames.
// ----------------------------------------------------------------------------
// load, tick, stop and unused-mode transactions: after acceptance the decode
//   and output states run, then the result register; none is accepted until then
// play start and segment advance: per channel, the read, latch, divide and write
//   states too, the shared restoring divider giving one quotient bit a cycle
// reset: synchronous active-low rst_n clears play state, positions,
//   increments and keyframe valid bits at once, no clearing pass
module keyframe_linear_interpolator #(
  parameter int FRAMES   = kli_pkg::DEF_FRAMES,
  parameter int CHANNELS = kli_pkg::DEF_CHANNELS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kli_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kli_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input transactions
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // frame_index [2:0], channel_index [6:3], key_value [22:7], zero [23]
  input  logic [kli_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode [1:0]
  input  logic [kli_pkg::MODE_W-1:0]      in_tuser,
  // result transactions
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // pos_ch0 [31:0] .. pos_ch8 [287:256], playing [288], segment [291:289],
  // zero [295:292]
  output logic [kli_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import kli_pkg::*;

  cmd_t    cmd;
  status_t status;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencer
  kli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // storage, arithmetic and result register
  kli_datapath #(
    .FRAMES   (FRAMES),
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .status     (status),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  // one transaction in flight: no new acceptance right after one
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a transaction is in flight");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_tvalid && !out_tready))
    else $error("result register overwritten");

  // at most one state update per decode
  a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.kf_write, cmd.step, cmd.stop_end, cmd.halt, cmd.start, cmd.advance}))
    else $error("conflicting play state commands");

endmodule
